/* rtl/core/ppc_pkg.sv */
// Shared types, constants and helper functions for the pinhole projection core.
package ppc_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int FocalWidth = 31;
  localparam int PoseCount  = 12;
  localparam int PoseIdxW   = 4;
  localparam int RegIdxW    = 3;
  localparam int DivWidth   = 64;
  localparam int QueueDepth = 4;
  localparam int AccWidth   = 2 * CoordWidth - FracBits + 2;

  localparam logic [FocalWidth-1:0] FocalReset  = FocalWidth'(1000 * 2 ** FracBits);
  localparam logic [CoordWidth-1:0] CenterXReset = CoordWidth'(320 * 2 ** FracBits);
  localparam logic [CoordWidth-1:0] CenterYReset = CoordWidth'(240 * 2 ** FracBits);
  localparam logic [CoordWidth-1:0] OneFixed     = CoordWidth'(2 ** FracBits);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [AccWidth-1:0] acc_t;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_AXIS_SKEW = 3'd4
  } reg_idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } cam_t;

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic behind;
  } side_t;

  function automatic coord_t pose_reset(input int i);
    return (i == 0 || i == 4 || i == 8) ? coord_t'(OneFixed) : coord_t'(0);
  endfunction

  function automatic coord_t sat_coord(input acc_t x);
    coord_t r;
    r = x[CoordWidth-1:0];
    if (x[AccWidth-1:CoordWidth-1] != {(AccWidth-CoordWidth+1){1'b0}} &&
        x[AccWidth-1:CoordWidth-1] != {(AccWidth-CoordWidth+1){1'b1}}) begin
      r = x[AccWidth-1] ? {1'b1, {(CoordWidth-1){1'b0}}} : {1'b0, {(CoordWidth-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic coord_t sat_quo(input logic [DivWidth-1:0] q, input logic neg);
    logic   over;
    coord_t r;
    over = (q[DivWidth-1:CoordWidth-1] != '0);
    if (!neg) begin
      r = over ? {1'b0, {(CoordWidth-1){1'b1}}} : coord_t'(q[CoordWidth-1:0]);
    end else begin
      r = over ? {1'b1, {(CoordWidth-1){1'b0}}} : -coord_t'(q[CoordWidth-1:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/core/ppc_if.sv */
// Channel interfaces: point input, pixel result and configuration write.
interface ppc_pt_if import ppc_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [PoseIdxW-1:0] pose_index;
  coord_t              pose_value;
  coord_t              point_x;
  coord_t              point_y;
  coord_t              point_z;
  modport source(output valid, op, pose_index, pose_value, point_x, point_y, point_z,
                 input ready);
  modport sink(input valid, op, pose_index, pose_value, point_x, point_y, point_z,
               output ready);
endinterface

interface ppc_px_if import ppc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   behind_camera;
  modport source(output valid, pixel_x, pixel_y, behind_camera, input ready);
  modport sink(input valid, pixel_x, pixel_y, behind_camera, output ready);
endinterface

interface ppc_cfg_if import ppc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] reg_index;
  logic [31:0]        data;
  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

/* rtl/core/ppc_front.sv */
// Front end: pose store, item decode and world-to-camera transform.
module ppc_front import ppc_pkg::*; (
  input  logic clk,
  input  logic rst,
  ppc_pt_if.sink pt,
  input  logic q_full,
  output logic q_push,
  output cam_t q_data
);

  coord_t pose [PoseCount];
  coord_t pnt [3];
  coord_t trans [3];
  logic signed [2*CoordWidth-1:0] prod [3][3];
  logic f1_v;
  logic take;
  acc_t acc [3];

  assign pnt[0] = pt.point_x;
  assign pnt[1] = pt.point_y;
  assign pnt[2] = pt.point_z;

  assign pt.ready = !f1_v || !q_full;
  assign take     = pt.valid && pt.ready;
  assign q_push   = f1_v && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PoseCount; i++) pose[i] <= pose_reset(i);
    end else if (take && pt.op == OP_LOAD && pt.pose_index < PoseIdxW'(PoseCount)) begin
      pose[pt.pose_index] <= pt.pose_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (pt.ready) begin
      f1_v <= take && pt.op == OP_PROJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (pt.ready) begin
      for (int i = 0; i < 3; i++) begin
        trans[i] <= pose[9+i];
        for (int j = 0; j < 3; j++) prod[i][j] <= pose[i*3+j] * pnt[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = acc_t'(trans[i]);
      for (int j = 0; j < 3; j++) acc[i] = acc[i] + acc_t'(prod[i][j] >>> FracBits);
    end
  end

  assign q_data.x = sat_coord(acc[0]);
  assign q_data.y = sat_coord(acc[1]);
  assign q_data.z = sat_coord(acc[2]);

endmodule

/* rtl/core/ppc_queue.sv */
// Small FIFO of camera points between the front end and the back end.
module ppc_queue import ppc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cam_t push_data,
  input  logic pop,
  output cam_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cam_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = count == CntW'(QueueDepth);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QueueDepth)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");

endmodule

/* rtl/core/ppc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module ppc_div import ppc_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DivWidth-1:0]   dvd,
  input  logic [FocalWidth-1:0] den,
  output logic [DivWidth-1:0]   quo
);

  logic [DivWidth-1:0]   qr  [DivWidth];
  logic [FocalWidth-1:0] rem [DivWidth];
  logic [FocalWidth-1:0] dd  [DivWidth];

  for (genvar k = 0; k < DivWidth; k++) begin : g_stage
    logic [DivWidth-1:0]   qr_in;
    logic [FocalWidth-1:0] rem_in;
    logic [FocalWidth-1:0] dd_in;
    logic [FocalWidth:0]   trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign qr_in  = dvd;
      assign rem_in = '0;
      assign dd_in  = den;
    end else begin : g_next
      assign qr_in  = qr[k-1];
      assign rem_in = rem[k-1];
      assign dd_in  = dd[k-1];
    end

    assign trial = {rem_in, qr_in[DivWidth-1]};
    assign ge    = trial >= {1'b0, dd_in};

    always_ff @(posedge clk) begin
      if (en) begin
        qr[k]  <= {qr_in[DivWidth-2:0], ge};
        rem[k] <= ge ? FocalWidth'(trial - {1'b0, dd_in}) : trial[FocalWidth-1:0];
        dd[k]  <= dd_in;
      end
    end
  end

  assign quo = qr[DivWidth-1];

endmodule

/* rtl/core/ppc_back.sv */
// Back end: intrinsic matrix, perspective divide, saturation and result register.
module ppc_back import ppc_pkg::*; (
  input  logic clk,
  input  logic rst,
  ppc_cfg_if.sink cfg,
  ppc_px_if.source px,
  input  logic q_empty,
  input  cam_t q_data,
  output logic q_pop
);

  logic [FocalWidth-1:0] focal_x;
  logic [FocalWidth-1:0] focal_y;
  coord_t center_x;
  coord_t center_y;
  coord_t axis_skew;

  logic back_en;
  logic out_v;

  logic b1_v;
  logic signed [2*CoordWidth-1:0] pu0, pu1, pu2, pv0, pv1;
  logic b1_behind;
  logic [FocalWidth-1:0] b1_den;

  acc_t u, v;
  logic [AccWidth-1:0] mag_u, mag_v;

  logic b2_v;
  side_t b2_side;
  logic [DivWidth-1:0] dvd_u, dvd_v;
  logic [FocalWidth-1:0] b2_den;

  logic [DivWidth-1:0] dv;
  side_t side [DivWidth];
  logic [DivWidth-1:0] quo_u, quo_v;

  coord_t pixel_x;
  coord_t pixel_y;
  logic   behind_camera;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x   <= FocalReset;
      focal_y   <= FocalReset;
      center_x  <= CenterXReset;
      center_y  <= CenterYReset;
      axis_skew <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_FOCAL_X:   focal_x   <= cfg.data[FocalWidth-1:0];
        REG_FOCAL_Y:   focal_y   <= cfg.data[FocalWidth-1:0];
        REG_CENTER_X:  center_x  <= cfg.data;
        REG_CENTER_Y:  center_y  <= cfg.data;
        REG_AXIS_SKEW: axis_skew <= cfg.data;
        default: ;
      endcase
    end
  end

  assign back_en = !out_v || px.ready;
  assign q_pop   = back_en && !q_empty;

  // control line
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v  <= 1'b0;
      b2_v  <= 1'b0;
      dv    <= '0;
      out_v <= 1'b0;
    end else if (back_en) begin
      b1_v  <= !q_empty;
      b2_v  <= b1_v;
      dv    <= {dv[DivWidth-2:0], b2_v};
      out_v <= dv[DivWidth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      pu0       <= $signed({1'b0, focal_x}) * q_data.x;
      pu1       <= axis_skew * q_data.y;
      pu2       <= center_x * q_data.z;
      pv0       <= $signed({1'b0, focal_y}) * q_data.y;
      pv1       <= center_y * q_data.z;
      b1_behind <= q_data.z[CoordWidth-1] || q_data.z == '0;
      b1_den    <= q_data.z[FocalWidth-1:0];
    end
  end

  assign u = acc_t'(pu0 >>> FracBits) + acc_t'(pu1 >>> FracBits) + acc_t'(pu2 >>> FracBits);
  assign v = acc_t'(pv0 >>> FracBits) + acc_t'(pv1 >>> FracBits);
  assign mag_u = u[AccWidth-1] ? AccWidth'(-u) : AccWidth'(u);
  assign mag_v = v[AccWidth-1] ? AccWidth'(-v) : AccWidth'(v);

  always_ff @(posedge clk) begin
    if (back_en) begin
      b2_side.neg_u  <= u[AccWidth-1];
      b2_side.neg_v  <= v[AccWidth-1];
      b2_side.behind <= b1_behind;
      dvd_u          <= {mag_u[DivWidth-FracBits-1:0], {FracBits{1'b0}}};
      dvd_v          <= {mag_v[DivWidth-FracBits-1:0], {FracBits{1'b0}}};
      b2_den         <= b1_den;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      side[0] <= b2_side;
      for (int k = 1; k < DivWidth; k++) side[k] <= side[k-1];
    end
  end

  ppc_div u_div_x (.clk(clk), .en(back_en), .dvd(dvd_u), .den(b2_den), .quo(quo_u));
  ppc_div u_div_y (.clk(clk), .en(back_en), .dvd(dvd_v), .den(b2_den), .quo(quo_v));

  always_ff @(posedge clk) begin
    if (back_en) begin
      behind_camera <= side[DivWidth-1].behind;
      pixel_x <= side[DivWidth-1].behind ? '0 : sat_quo(quo_u, side[DivWidth-1].neg_u);
      pixel_y <= side[DivWidth-1].behind ? '0 : sat_quo(quo_v, side[DivWidth-1].neg_v);
    end
  end

  assign px.valid         = out_v;
  assign px.pixel_x       = pixel_x;
  assign px.pixel_y       = pixel_y;
  assign px.behind_camera = behind_camera;

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    out_v && behind_camera |-> pixel_x == '0 && pixel_y == '0)
    else $error("pixels not zero behind camera");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_v && !px.ready |=> out_v && $stable(pixel_x) && $stable(dv))
    else $error("pipeline moved while result stalled");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> b1_v) else $error("popped transaction lost");

endmodule

/* rtl/core/pinhole_point_projection_core.sv */
// Top level of the pinhole point projection core.
//
// Channels: pt carries input transactions (op = load a pose word or project a
// point), px carries one result per projection, cfg writes the intrinsic
// registers (focal_x, focal_y, center_x, center_y, axis_skew by index 0..4).
// cfg is always ready; it is to be written while the core is idle, which the core itself does not enforce.
// Loads update the pose at acceptance and produce no result.
// Throughput: one transaction per cycle when px is ready.
// Path from acceptance to px.valid: one transform stage, the
// queue write, two intrinsic stages, 64 stages of the perspective divider
// (one quotient bit per stage) and the result register.
// Reset gives identity rotation, zero translation, focal 1000.0, center
// (320.0, 240.0), zero skew, and empties the pipeline.
// When px stalls, the whole back end holds; the four-entry queue absorbs
// the front end's output, then pt.ready drops.
module pinhole_point_projection_core import ppc_pkg::*; (
  input logic clk,
  input logic rst,
  ppc_pt_if.sink pt,
  ppc_px_if.source px,
  ppc_cfg_if.sink cfg
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cam_t q_in;
  cam_t q_out;

  ppc_front u_front (
    .clk(clk), .rst(rst), .pt(pt), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  ppc_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .pop(q_pop),
    .pop_data(q_out), .full(q_full), .empty(q_empty)
  );

  ppc_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .px(px), .q_empty(q_empty), .q_data(q_out),
    .q_pop(q_pop)
  );

endmodule

/* verif/ppc_proj_checker.sv */
// Monitor, pixel predictor and scoreboard for the pinhole projection core.
`timescale 1ns / 100ps
module ppc_proj_checker import ppc_pkg::*; (
  input logic clk,
  input logic rst,
  ppc_pt_if   pt,
  ppc_px_if   px,
  ppc_cfg_if  cfg,
  output int  fails,
  output int  pending
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   behind;
  } pixel_t;

  coord_t                pose_mem [PoseCount];
  logic [FocalWidth-1:0] fx_r, fy_r;
  coord_t                cx_r, cy_r, skew_r;
  pixel_t                pixels_due [$];

  function automatic longint clamp32(input longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FracBits;
  endfunction

  function automatic coord_t persp_div(input longint num, input longint den);
    logic        neg;
    logic [63:0] mag, q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << FracBits) / den;
    if (!neg) return (q > 64'h7fffffff) ? 32'sh7fffffff : coord_t'(q);
    if (q > 64'h7fffffff) return 32'sh80000000;
    return -coord_t'(q);
  endfunction

  function automatic pixel_t project_point(input coord_t wx, input coord_t wy, input coord_t wz);
    longint w [3];
    longint c [3];
    longint acc, u, v;
    pixel_t r;
    w[0] = wx; w[1] = wy; w[2] = wz;
    for (int i = 0; i < 3; i++) begin
      acc = longint'(pose_mem[9 + i]);
      for (int j = 0; j < 3; j++) acc += qmul(longint'(pose_mem[i * 3 + j]), w[j]);
      c[i] = clamp32(acc);
    end
    if (c[2] <= 0) begin
      r = '{x: '0, y: '0, behind: 1'b1};
      return r;
    end
    u = qmul(longint'({1'b0, fx_r}), c[0]) + qmul(longint'(skew_r), c[1])
        + qmul(longint'(cx_r), c[2]);
    v = qmul(longint'({1'b0, fy_r}), c[1]) + qmul(longint'(cy_r), c[2]);
    r.x = persp_div(u, c[2]);
    r.y = persp_div(v, c[2]);
    r.behind = 1'b0;
    return r;
  endfunction

  assign pending = pixels_due.size();

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      for (int i = 0; i < PoseCount; i++)
        pose_mem[i] = (i == 0 || i == 4 || i == 8) ? coord_t'(1 << FracBits) : '0;
      fx_r = FocalWidth'(1000 << FracBits);
      fy_r = FocalWidth'(1000 << FracBits);
      cx_r = 320 << FracBits;
      cy_r = 240 << FracBits;
      skew_r = '0;
      pixels_due.delete();
      fails = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_FOCAL_X:   fx_r = cfg.data[FocalWidth-1:0];
          REG_FOCAL_Y:   fy_r = cfg.data[FocalWidth-1:0];
          REG_CENTER_X:  cx_r = cfg.data;
          REG_CENTER_Y:  cy_r = cfg.data;
          REG_AXIS_SKEW: skew_r = cfg.data;
          default: ;
        endcase
      end
      if (px.valid && px.ready) begin
        got = '{x: px.pixel_x, y: px.pixel_y, behind: px.behind_camera};
        if (pixels_due.size() == 0) begin
          $error("pixel transaction with nothing expected: x=%h y=%h behind=%b",
                 got.x, got.y, got.behind);
          fails++;
        end else begin
          want = pixels_due.pop_front();
          if (got.x !== want.x) begin
            $error("pixel_x expected %h actual %h", want.x, got.x); fails++;
          end
          if (got.y !== want.y) begin
            $error("pixel_y expected %h actual %h", want.y, got.y); fails++;
          end
          if (got.behind !== want.behind) begin
            $error("behind_camera expected %b actual %b", want.behind, got.behind); fails++;
          end
        end
      end
      if (pt.valid && pt.ready) begin
        if (pt.op == OP_PROJECT)
          pixels_due.push_back(project_point(pt.point_x, pt.point_y, pt.point_z));
        else if (pt.pose_index < PoseCount)
          pose_mem[pt.pose_index] = pt.pose_value;
      end
    end
  end

endmodule

/* verif/tb_pinhole_point_projection_core.sv */
// Stimulus, clocking and verdict for the pinhole projection core.
`timescale 1ns / 100ps
module tb_pinhole_point_projection_core;
  import ppc_pkg::*;

  localparam int  Drain = 90;
  localparam longint Limit = 3000000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  int     fails, pending;
  longint cycles = 0;
  int     n_proj = 0, n_load = 0, n_cfg = 0;
  int     burst_left = 0;
  int     stall_mode = 0;

  ppc_pt_if  pt();
  ppc_px_if  px();
  ppc_cfg_if cfg();

  pinhole_point_projection_core i_dut (.clk(clk), .rst(rst), .pt(pt), .px(px), .cfg(cfg));

  ppc_proj_checker i_chk (.clk(clk), .rst(rst), .pt(pt), .px(px), .cfg(cfg),
                          .fails(fails), .pending(pending));

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result-side backpressure in one of four randomly chosen modes
  always @(negedge clk) begin
    if (cycles % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: px.ready <= 1'b1;
      1: px.ready <= ($urandom_range(0, 3) != 0);
      2: px.ready <= (cycles % 4 == 0);
      default: px.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic put(input op_t o, input logic [PoseIdxW-1:0] idx, input coord_t val,
                     input coord_t x, input coord_t y, input coord_t z);
    int gap;
    @(negedge clk);
    pt.valid <= 1'b1; pt.op <= o; pt.pose_index <= idx; pt.pose_value <= val;
    pt.point_x <= x; pt.point_y <= y; pt.point_z <= z;
    do @(posedge clk); while (!pt.ready);
    if (o == OP_PROJECT) n_proj++; else n_load++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        pt.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic project(input coord_t x, input coord_t y, input coord_t z);
    put(OP_PROJECT, 4'($urandom), $urandom, x, y, z);
  endtask

  task automatic load(input logic [PoseIdxW-1:0] idx, input coord_t val);
    put(OP_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic quiesce();
    @(negedge clk);
    pt.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg.valid <= 1'b1; cfg.reg_index <= idx; cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_intrinsics(input logic [31:0] fx, input logic [31:0] fy,
                                input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] sk);
    quiesce();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_AXIS_SKEW, sk);
    for (int k = 1; k <= 3; k++) write_reg(3'(REG_AXIS_SKEW + k), $urandom);
    n_cfg++;
  endtask

  function automatic coord_t near_val(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_pose();
    for (int i = 0; i < 9; i++)
      load(4'(i), (i % 4 == 0) ? coord_t'(32'h10000) + near_val(32'h8000) : near_val(32'h8000));
    for (int i = 9; i < 12; i++)
      load(4'(i), (i == 11) ? coord_t'($urandom_range(32'h10000, 32'h200000))
                            : near_val(32'h100000));
  endtask

  task automatic random_items(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) load(4'($urandom_range(0, 11)), near_val(32'h10000) + 32'h8000);
      else if (r < 9) load(4'($urandom_range(0, 15)), $urandom);
      else if (r < 11) random_pose();
      else if (r < 20) project($urandom, $urandom, $urandom);
      else if (r < 28) project(near_val(32'h1000000), near_val(32'h1000000),
                               near_val(32'h10000));
      else project(near_val(32'h1000000), near_val(32'h1000000),
                   $urandom_range(32'h100, 32'h2000000));
    end
  endtask

  initial begin
    pt.valid = 1'b0; pt.op = OP_LOAD; pt.pose_index = '0; pt.pose_value = '0;
    pt.point_x = '0; pt.point_y = '0; pt.point_z = '0;
    cfg.valid = 1'b0; cfg.reg_index = REG_FOCAL_X; cfg.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset intrinsics, identity pose
    project(0, 0, 32'h10000);
    project(32'h10000, 32'h20000, 32'h40000);
    project(32'h5000, -32'h5000, 0);
    project(32'h5000, 32'h5000, -32'h10000);
    project(32'h80000000, 32'h80000000, 32'h80000000);
    project(32'h7fffffff, 32'h80000000, 32'h1);
    project(32'h80000000, 32'h7fffffff, 32'h1);
    project(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    project(32'hffffffff, 32'h1, 32'h7fffffff);
    load(4'd12, 32'h12345678);
    load(4'd15, 32'h80000000);
    project(32'h30000, 32'h30000, 32'h10000);
    load(4'd11, 32'h50000);
    project(-32'h20000, 32'h10000, 32'h10000);
    load(4'd0, 32'h80000000);
    project(32'h10000, 0, 32'h10000);
    load(4'd0, 32'h7fffffff);
    load(4'd9, 32'h7fffffff);
    project(32'h7fffffff, 32'h7fffffff, 32'h10000);
    load(4'd0, 32'h10000);
    load(4'd9, 0);
    load(4'd11, -32'h50000);
    project(0, 0, 32'h10000);
    load(4'd11, 0);

    set_intrinsics(32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    random_items(100);
    set_intrinsics(0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff);
    random_items(100);
    set_intrinsics($urandom, $urandom, $urandom, $urandom, $urandom);
    random_items(100);
    set_intrinsics($urandom_range(32'h10000, 32'h8000000), $urandom_range(32'h10000, 32'h8000000),
                   near_val(32'h4000000), near_val(32'h4000000), near_val(32'h100000));
    random_items(200);
    set_intrinsics(32'h3e80000, 32'h3e80000, 32'h1400000, 32'hf00000, 0);
    random_items(180);

    quiesce();
    $display("covered %0d projections and %0d pose loads across %0d intrinsic settings",
             n_proj, n_load, n_cfg + 1);
    if (fails == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
